// ----- src/wss_pkg.sv -----
// Shared types and constants of the windowed sample statistics unit.
package wss_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TIME_BITS = 63;
  localparam int WIN_BITS = 8;
  localparam int OP_BITS = 4;
  localparam int IN_TDATA_W = 104;
  localparam int OUT_TDATA_W = 232;

  localparam logic [OP_BITS-1:0] OP_PUSH = 4'd0;
  localparam logic [OP_BITS-1:0] OP_PEAK = 4'd1;
  localparam logic [OP_BITS-1:0] OP_PEAK_RST = 4'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 4'd3;
  localparam logic [OP_BITS-1:0] OP_MEAN = 4'd4;
  localparam logic [OP_BITS-1:0] OP_STDDEV = 4'd5;
  localparam logic [OP_BITS-1:0] OP_MIN = 4'd6;
  localparam logic [OP_BITS-1:0] OP_MAX = 4'd7;
  localparam logic [OP_BITS-1:0] OP_SAMPLE = 4'd8;
  localparam logic [OP_BITS-1:0] OP_STATUS = 4'd9;

  localparam logic REG_ERROR_VALUE = 1'b0;
  localparam logic REG_ERR_CMP_EN = 1'b1;

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  localparam logic [1:0] ARITH_MUL = 2'd0;
  localparam logic [1:0] ARITH_DIV = 2'd1;
  localparam logic [1:0] ARITH_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } arith_req_t;

endpackage

// ----- src/wss_arith.sv -----
// Bit-serial shared unit: shift-add multiply, restoring divide and integer square root.
module wss_arith #(
  parameter int SW = 39
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wss_pkg::arith_req_t  req,
  input  logic [2*SW-1:0]      opa,
  input  logic [SW-1:0]        opb,
  output logic                 done,
  output logic [2*SW-1:0]      result
);

  localparam int MW = 2 * SW;
  localparam int KW = $clog2(SW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] acc_r, acc_nxt;
  logic [MW-1:0] a_r, a_nxt;
  logic [SW-1:0] b_r, b_nxt;
  logic [SW+1:0] rem_r, rem_nxt;

  always_comb begin
    logic [SW+1:0] rem_div;
    logic [SW+1:0] rem_sq;
    logic [SW+1:0] trial;
    rem_div = {rem_r[SW:0], a_r[SW-1]};
    rem_sq = {rem_r[SW-1:0], a_r[MW-1 -: 2]};
    trial = {acc_r[SW-1:0], 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    rem_nxt = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt = req.op;
      cnt_nxt = KW'(SW);
      acc_nxt = '0;
      a_nxt = opa;
      b_nxt = opb;
      rem_nxt = '0;
    end else if (busy_r) begin
      case (op_r)
        wss_pkg::ARITH_MUL: begin
          acc_nxt = {acc_r[MW-2:0], 1'b0} + (b_r[SW-1] ? a_r : '0);
          b_nxt = {b_r[SW-2:0], 1'b0};
        end
        wss_pkg::ARITH_DIV: begin
          if (rem_div >= {2'b00, b_r}) begin
            rem_nxt = rem_div - {2'b00, b_r};
            acc_nxt = {acc_r[MW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_div;
            acc_nxt = {acc_r[MW-2:0], 1'b0};
          end
          a_nxt = {a_r[MW-2:0], 1'b0};
        end
        wss_pkg::ARITH_SQRT: begin
          if (rem_sq >= trial) begin
            rem_nxt = rem_sq - trial;
            acc_nxt = {acc_r[MW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sq;
            acc_nxt = {acc_r[MW-2:0], 1'b0};
          end
          a_nxt = {a_r[MW-3:0], 2'b00};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == KW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign result = acc_r;

endmodule

// ----- src/windowed_sample_statistics_unit.sv -----
// Top level of the windowed sample statistics unit: ring store, scan sequencer and ports.
//
// One operation is taken at a time; in_tready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next operation is accepted. Push,
// peak tracking, peak reset, clear and status pass through an execute and a response state; sample
// lookup adds a store read and check state between them. A min or max query over k samples makes
// one store read per cycle through a three-stage read, square and accumulate pipeline. Mean then
// runs a bit-serial divide of VALUE_BITS + clog2(HISTORY_DEPTH+1) steps (39 by default) and takes
// the quotient. Standard deviation over two or more usable samples adds four such passes through
// the same shared unit (multiply, square, root, divide). The store needs no clearing pass after
// reset.
module windowed_sample_statistics_unit #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sample_value[31:0], sample_valid[32], event_time[95:33], window_length[103:96]
  input  logic [wss_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation[3:0]
  input  logic [wss_pkg::OP_BITS-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_value[31:0], stored_count[38:32], push_overwrote[39], peak_low[71:40],
  // peak_high[103:72], peak_low_time[166:104], peak_high_time[229:167]
  output logic [wss_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // result_is_error[0]
  output logic [0:0]                       out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int VB = wss_pkg::VALUE_BITS;
  localparam int TW = wss_pkg::TIME_BITS;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int SW = VB + CW;
  localparam int MW = 2 * SW;
  localparam int XW = (CW > 8) ? CW : 8;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EXEC = 4'd1;
  localparam logic [3:0] ST_SCAN = 4'd2;
  localparam logic [3:0] ST_SCHK = 4'd3;
  localparam logic [3:0] ST_MEAN = 4'd4;
  localparam logic [3:0] ST_MUL1 = 4'd5;
  localparam logic [3:0] ST_MUL2 = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_SDIV = 4'd8;
  localparam logic [3:0] ST_RESP = 4'd9;

  logic [3:0]                     state_r, state_nxt;
  logic [wss_pkg::OP_BITS-1:0]    op_r, op_nxt;
  logic signed [VB-1:0]           val_r, val_nxt;
  logic                           vld_r, vld_nxt;
  logic [TW-1:0]                  time_r, time_nxt;
  logic signed [7:0]              win_r, win_nxt;
  logic signed [VB-1:0]           err_val_r, err_val_nxt;
  logic                           cmp_en_r, cmp_en_nxt;
  logic [PW-1:0]                  oldest_r, oldest_nxt;
  logic [CW-1:0]                  held_r, held_nxt;
  logic signed [VB-1:0]           low_r, low_nxt;
  logic signed [VB-1:0]           high_r, high_nxt;
  logic [TW-1:0]                  low_t_r, low_t_nxt;
  logic [TW-1:0]                  high_t_r, high_t_nxt;
  logic                           peak_r, peak_nxt;
  logic signed [VB-1:0]           res_r, res_nxt;
  logic                           res_err_r, res_err_nxt;
  logic                           ovw_r, ovw_nxt;
  logic [CW-1:0]                  i_r, i_nxt;
  logic                           s1v_r, s1v_nxt;
  logic                           s2v_r, s2v_nxt;
  logic                           u2_r, u2_nxt;
  logic signed [VB-1:0]           v2_r, v2_nxt;
  logic [2*VB-1:0]                sq2_r, sq2_nxt;
  logic [CW-1:0]                  n_r, n_nxt;
  logic signed [SW-1:0]           s1_r, s1_nxt;
  logic [MW-1:0]                  s2_r, s2_nxt;
  logic signed [VB-1:0]           best_r, best_nxt;
  logic [MW-1:0]                  prod_r, prod_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [wss_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                           out_tuser_r, out_tuser_nxt;

  logic [VB:0]                    mem [HISTORY_DEPTH];
  logic [VB:0]                    rd_data_r;
  logic [PW-1:0]                  rd_addr;
  logic [PW-1:0]                  wr_addr;
  logic                           wr_en;

  wss_pkg::arith_req_t            ar_req;
  logic [MW-1:0]                  ar_a;
  logic [SW-1:0]                  ar_b;
  logic                           ar_done;
  logic [MW-1:0]                  ar_result;

  logic signed [VB-1:0]           rd_val;
  logic [VB-1:0]                  rd_mag;
  logic                           rd_use;
  logic [SW-1:0]                  mag_s1;
  logic                           cfg_wr;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(HISTORY_DEPTH)) begin
      s = s - (CW+1)'(HISTORY_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign rd_val = rd_data_r[VB-1:0];
  assign rd_mag = rd_val[VB-1] ? VB'(-rd_val) : VB'(rd_val);
  assign rd_use = rd_data_r[VB] && !(cmp_en_r && (rd_val == err_val_r));
  assign mag_s1 = s1_r[SW-1] ? SW'(-s1_r) : SW'(s1_r);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  wss_arith #(.SW(SW)) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ar_req),
    .opa    (ar_a),
    .opb    (ar_b),
    .done   (ar_done),
    .result (ar_result)
  );

  always_comb begin
    logic [CW-1:0] k_len;
    logic [7:0]    a_mag;
    logic [CW-1:0] s_idx;
    logic [VB-1:0] q;
    k_len = held_r;
    a_mag = win_r[7] ? 8'(-win_r) : 8'(win_r);
    s_idx = '0;
    q = ar_result[VB-1:0];
    state_nxt = state_r;
    op_nxt = op_r;
    val_nxt = val_r;
    vld_nxt = vld_r;
    time_nxt = time_r;
    win_nxt = win_r;
    err_val_nxt = err_val_r;
    cmp_en_nxt = cmp_en_r;
    oldest_nxt = oldest_r;
    held_nxt = held_r;
    low_nxt = low_r;
    high_nxt = high_r;
    low_t_nxt = low_t_r;
    high_t_nxt = high_t_r;
    peak_nxt = peak_r;
    res_nxt = res_r;
    res_err_nxt = res_err_r;
    ovw_nxt = ovw_r;
    i_nxt = i_r;
    s1v_nxt = 1'b0;
    s2v_nxt = s1v_r;
    u2_nxt = rd_use;
    v2_nxt = rd_val;
    sq2_nxt = rd_mag * rd_mag;
    n_nxt = n_r;
    s1_nxt = s1_r;
    s2_nxt = s2_r;
    best_nxt = best_r;
    prod_nxt = prod_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    rd_addr = phys(oldest_r, i_r);
    wr_addr = phys(oldest_r, held_r);
    wr_en = 1'b0;
    ar_req.start = 1'b0;
    ar_req.op = wss_pkg::ARITH_MUL;
    ar_a = '0;
    ar_b = '0;

    if (cfg_wr) begin
      case (cfg_paddr[2])
        wss_pkg::REG_ERROR_VALUE: err_val_nxt = cfg_pwdata;
        default: cmp_en_nxt = cfg_pwdata[0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tuser;
          val_nxt = in_tdata[31:0];
          vld_nxt = in_tdata[32];
          time_nxt = in_tdata[95:33];
          win_nxt = in_tdata[103:96];
          res_nxt = '0;
          res_err_nxt = 1'b0;
          ovw_nxt = 1'b0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        unique case (op_r) inside
          wss_pkg::OP_PUSH: begin
            wr_en = 1'b1;
            if (held_r >= CW'(HISTORY_DEPTH)) begin
              ovw_nxt = 1'b1;
              oldest_nxt = (oldest_r == PW'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
            end else begin
              held_nxt = held_r + 1'b1;
            end
          end
          wss_pkg::OP_PEAK: begin
            if (vld_r) begin
              if (!peak_r || val_r > high_r) begin
                high_nxt = val_r;
                high_t_nxt = time_r;
              end
              if (!peak_r || val_r < low_r) begin
                low_nxt = val_r;
                low_t_nxt = time_r;
              end
              peak_nxt = 1'b1;
            end
          end
          wss_pkg::OP_PEAK_RST: begin
            low_nxt = wss_pkg::VAL_MAX;
            high_nxt = wss_pkg::VAL_MIN;
            low_t_nxt = '0;
            high_t_nxt = '0;
            peak_nxt = 1'b0;
          end
          wss_pkg::OP_CLEAR: begin
            held_nxt = '0;
            oldest_nxt = '0;
          end
          wss_pkg::OP_MEAN, wss_pkg::OP_STDDEV, wss_pkg::OP_MIN, wss_pkg::OP_MAX: begin
            if (!win_r[7] && (XW'($unsigned(win_r)) < XW'(held_r))) begin
              k_len = CW'($unsigned(win_r));
            end
            i_nxt = held_r - k_len;
            n_nxt = '0;
            s1_nxt = '0;
            s2_nxt = '0;
            best_nxt = '0;
            s2v_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
          wss_pkg::OP_SAMPLE: begin
            if (held_r == '0 || XW'(held_r) < XW'(a_mag)) begin
              res_nxt = err_val_r;
              res_err_nxt = 1'b1;
            end else begin
              if (win_r > 8'sd0) begin
                s_idx = held_r - CW'(a_mag);
              end else if (win_r < 8'sd0) begin
                s_idx = CW'(a_mag) - 1'b1;
              end
              rd_addr = phys(oldest_r, s_idx);
              state_nxt = ST_SCHK;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_SCAN: begin
        if (i_r < held_r) begin
          s1v_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
        end
        if (s2v_r && u2_r) begin
          if (n_r == '0 || (op_r == wss_pkg::OP_MIN && v2_r < best_r) ||
              (op_r == wss_pkg::OP_MAX && v2_r > best_r)) begin
            best_nxt = v2_r;
          end
          n_nxt = n_r + 1'b1;
          s1_nxt = s1_r + SW'(v2_r);
          s2_nxt = s2_r + MW'(sq2_r);
        end
        if (i_r >= held_r && !s1v_r && !s2v_r) begin
          state_nxt = ST_RESP;
          if (op_r == wss_pkg::OP_STDDEV) begin
            if (n_r >= CW'(2)) begin
              ar_req.start = 1'b1;
              ar_req.op = wss_pkg::ARITH_MUL;
              ar_a = s2_r;
              ar_b = SW'(n_r);
              state_nxt = ST_MUL1;
            end
          end else if (n_r == '0) begin
            res_nxt = err_val_r;
            res_err_nxt = 1'b1;
          end else if (op_r == wss_pkg::OP_MEAN) begin
            ar_req.start = 1'b1;
            ar_req.op = wss_pkg::ARITH_DIV;
            ar_a = MW'(mag_s1 + SW'(n_r >> 1));
            ar_b = SW'(n_r);
            state_nxt = ST_MEAN;
          end else begin
            res_nxt = best_r;
          end
        end
      end
      ST_SCHK: begin
        if (rd_use) begin
          res_nxt = rd_val;
        end else begin
          res_nxt = err_val_r;
          res_err_nxt = 1'b1;
        end
        state_nxt = ST_RESP;
      end
      ST_MEAN: begin
        if (ar_done) begin
          res_nxt = s1_r[SW-1] ? -q : q;
          state_nxt = ST_RESP;
        end
      end
      ST_MUL1: begin
        if (ar_done) begin
          prod_nxt = ar_result;
          ar_req.start = 1'b1;
          ar_req.op = wss_pkg::ARITH_MUL;
          ar_a = MW'(mag_s1);
          ar_b = mag_s1;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (ar_done) begin
          ar_req.start = 1'b1;
          ar_req.op = wss_pkg::ARITH_SQRT;
          ar_a = prod_r - ar_result;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (ar_done) begin
          ar_req.start = 1'b1;
          ar_req.op = wss_pkg::ARITH_DIV;
          ar_a = MW'(ar_result[SW-1:0]);
          ar_b = SW'(n_r);
          state_nxt = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (ar_done) begin
          if (ar_result[SW-1:0] > SW'(wss_pkg::VAL_MAX)) begin
            res_nxt = wss_pkg::VAL_MAX;
          end else begin
            res_nxt = ar_result[VB-1:0];
          end
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt = {2'b00, high_t_r, low_t_r, high_r, low_r, ovw_r, 7'(held_r), res_r};
          out_tuser_nxt = res_err_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_val_r <= '0;
      cmp_en_r <= 1'b0;
      oldest_r <= '0;
      held_r <= '0;
      low_r <= wss_pkg::VAL_MAX;
      high_r <= wss_pkg::VAL_MIN;
      low_t_r <= '0;
      high_t_r <= '0;
      peak_r <= 1'b0;
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_val_r <= err_val_nxt;
      cmp_en_r <= cmp_en_nxt;
      oldest_r <= oldest_nxt;
      held_r <= held_nxt;
      low_r <= low_nxt;
      high_r <= high_nxt;
      low_t_r <= low_t_nxt;
      high_t_r <= high_t_nxt;
      peak_r <= peak_nxt;
      s1v_r <= s1v_nxt;
      s2v_r <= s2v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    val_r <= val_nxt;
    vld_r <= vld_nxt;
    time_r <= time_nxt;
    win_r <= win_nxt;
    res_r <= res_nxt;
    res_err_r <= res_err_nxt;
    ovw_r <= ovw_nxt;
    i_r <= i_nxt;
    u2_r <= u2_nxt;
    v2_r <= v2_nxt;
    sq2_r <= sq2_nxt;
    n_r <= n_nxt;
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    best_r <= best_nxt;
    prod_r <= prod_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {vld_r, val_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == wss_pkg::REG_ERR_CMP_EN) ? {31'd0, cmp_en_r} : err_val_r;

endmodule
